// ===== hdl/cbps_pkg.sv =====
// Shared types, codes and fixed widths of the cosine blend pose sequencer.
`timescale 1ns / 1ps

package cbps_pkg;

  localparam int TIME_W     = 27;
  localparam int VALUE_W    = 32;
  localparam int PERIOD_W   = 20;
  localparam int INDEX_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WEIGHT_W   = 17;

  typedef logic [1:0] op_t;
  typedef logic [1:0] phase_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_LOAD    = 2'd0;
  localparam op_t OP_CAPTURE = 2'd1;
  localparam op_t OP_TICK    = 2'd2;

  localparam phase_t PH_MOVE_A = 2'd0;
  localparam phase_t PH_HOLD   = 2'd1;
  localparam phase_t PH_MOVE_B = 2'd2;

  localparam cfg_idx_t CFG_MOVE_A_TIME    = 3'd0;
  localparam cfg_idx_t CFG_HOLD_TIME      = 3'd1;
  localparam cfg_idx_t CFG_MOVE_B_TIME    = 3'd2;
  localparam cfg_idx_t CFG_B_OFFSET       = 3'd3;
  localparam cfg_idx_t CFG_OFFSET_ELEMENT = 3'd4;

  localparam logic [TIME_W-1:0]  RST_MOVE_A_TIME    = 27'd3000000;
  localparam logic [TIME_W-1:0]  RST_HOLD_TIME      = 27'd5000000;
  localparam logic [TIME_W-1:0]  RST_MOVE_B_TIME    = 27'd2000000;
  localparam logic [VALUE_W-1:0] RST_B_OFFSET       = 32'd13421773;
  localparam logic [INDEX_W-1:0] RST_OFFSET_ELEMENT = 4'd13;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

endpackage

// ===== hdl/cosine_blend_pose_sequencer_unit.sv =====
// Three-phase cosine blend pose sequencer with pose memories and weight table.
// Load and capture beats are taken in the idle state, which they do not leave.
// In a move phase a tick beat forms the table index with a bit-serial divider,
// then each element walks a six-step read, blend and output sequence through
// the pose memories; the output step waits while out_stall is high.
// Synchronous reset restores the registers, clears elapsed time and phase.
`timescale 1ns / 1ps

module cosine_blend_pose_sequencer_unit
  import cbps_pkg::*;
#(
  parameter int POSE_ELEMENTS     = 16,
  parameter int BLEND_TABLE_DEPTH = 1024,
  parameter int ELEMENT_WIDTH     = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  input  logic [INDEX_W-1:0]      element_index,
  input  logic signed [VALUE_W-1:0] element_value,
  input  logic [PERIOD_W-1:0]     period_us,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [INDEX_W-1:0]      out_index,
  output logic signed [VALUE_W-1:0] pose_value,
  output logic [1:0]              phase,
  output logic                    last
);

  localparam int EB   = (ELEMENT_WIDTH > VALUE_W) ? VALUE_W : ELEMENT_WIDTH;
  localparam int IW   = (POSE_ELEMENTS > 1) ? $clog2(POSE_ELEMENTS) : 1;
  localparam int CMPW = ((IW > INDEX_W) ? IW : INDEX_W) + 1;
  localparam int KW   = $clog2(BLEND_TABLE_DEPTH + 1);
  localparam int DVW  = TIME_W + KW;
  localparam int CNTW = $clog2(DVW);
  localparam int DW   = EB + 1;
  localparam int PW   = EB + 19;
  localparam int SUMW = EB + 20;

  localparam logic signed [SUMW-1:0] EMAX = SUMW'((64'sd1 <<< (EB - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] EMIN = -EMAX - SUMW'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_ROM  = 4'd4;
  localparam logic [3:0] S_READ = 4'd5;
  localparam logic [3:0] S_BSEL = 4'd6;
  localparam logic [3:0] S_DIFF = 4'd7;
  localparam logic [3:0] S_PROD = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_OUTW = 4'd10;

  function automatic logic signed [EB-1:0] clamp_elem(input logic signed [SUMW-1:0] v);
    if (v > EMAX) begin
      return EMAX[EB-1:0];
    end
    if (v < EMIN) begin
      return EMIN[EB-1:0];
    end
    return v[EB-1:0];
  endfunction

  logic [WEIGHT_W-1:0] blend_rom [0:BLEND_TABLE_DEPTH];

  // Each entry is sin^2 in Q16, from a Taylor series in Q30, mirrored about the midpoint.
  for (genvar g = 0; g <= BLEND_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] KH = (2 * g <= BLEND_TABLE_DEPTH) ? 64'(g)
                                                             : 64'(BLEND_TABLE_DEPTH - g);
    localparam logic [63:0] Y  = (PI_Q30 * KH) / (64'd2 * 64'(BLEND_TABLE_DEPTH));
    localparam logic [63:0] T1 = ((((Y * Y) >> 30) * Y) >> 30) / 64'd6;
    localparam logic [63:0] S1 = (Y > T1) ? Y - T1 : 64'd0;
    localparam logic [63:0] T2 = ((((T1 * Y) >> 30) * Y) >> 30) / 64'd20;
    localparam logic [63:0] S2 = S1 + T2;
    localparam logic [63:0] T3 = ((((T2 * Y) >> 30) * Y) >> 30) / 64'd42;
    localparam logic [63:0] S3 = (S2 > T3) ? S2 - T3 : 64'd0;
    localparam logic [63:0] T4 = ((((T3 * Y) >> 30) * Y) >> 30) / 64'd72;
    localparam logic [63:0] S4 = S3 + T4;
    localparam logic [63:0] T5 = ((((T4 * Y) >> 30) * Y) >> 30) / 64'd110;
    localparam logic [63:0] S5 = (S4 > T5) ? S4 - T5 : 64'd0;
    localparam logic [63:0] T6 = ((((T5 * Y) >> 30) * Y) >> 30) / 64'd156;
    localparam logic [63:0] S6 = S5 + T6;
    localparam logic [63:0] SQ = (S6 * S6) >> 30;
    localparam logic [63:0] HALF = (SQ + 64'd8192) >> 14;
    localparam logic [WEIGHT_W-1:0] ENTRY = (2 * g <= BLEND_TABLE_DEPTH) ?
                                            WEIGHT_W'(HALF) :
                                            WEIGHT_W'(64'(WEIGHT_ONE) - HALF);
    assign blend_rom[g] = ENTRY;
  end

  logic [TIME_W-1:0]  move_a_time;
  logic [TIME_W-1:0]  hold_time;
  logic [TIME_W-1:0]  move_b_time;
  logic signed [VALUE_W-1:0] b_offset;
  logic [INDEX_W-1:0] offset_element;

  logic [3:0]         state;
  logic [31:0]        elapsed;
  logic [31:0]        elapsed_next;
  logic [32:0]        elapsed_sum;
  phase_t             phase_reg;
  phase_t             tick_phase;

  logic [31:0]        prep_num;
  logic [TIME_W-1:0]  prep_den;
  phase_t             prep_phase;

  logic [TIME_W-1:0]  div_num;
  logic [TIME_W-1:0]  div_den;
  logic [DVW-1:0]     dividend;
  logic [DVW-1:0]     dividend_next;
  logic [TIME_W-1:0]  rem;
  logic [TIME_W:0]    trial;
  logic               trial_ok;
  logic [CNTW-1:0]    div_count;
  logic [KW-1:0]      k_reg;
  logic [WEIGHT_W-1:0] rom_q;
  logic [WEIGHT_W-1:0] w_sel;

  logic signed [EB-1:0] start_mem  [0:POSE_ELEMENTS-1];
  logic signed [EB-1:0] target_mem [0:POSE_ELEMENTS-1];
  logic signed [EB-1:0] start_q;
  logic signed [EB-1:0] target_q;
  logic                 in_accept;
  logic                 idx_ok;
  logic                 start_we;
  logic                 target_we;
  logic [IW-1:0]        wr_addr;
  logic [IW-1:0]        elem;
  logic                 elem_last;
  logic                 offset_hit;

  logic signed [EB-1:0]   a_reg;
  logic signed [EB-1:0]   b_reg;
  logic signed [EB-1:0]   b_sel;
  logic signed [DW-1:0]   diff;
  logic signed [PW-1:0]   prod;
  logic signed [SUMW-1:0] sum;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign idx_ok    = (CMPW'(element_index) < CMPW'(POSE_ELEMENTS));
  assign wr_addr   = IW'(element_index);
  assign start_we  = in_accept && idx_ok && (operation == OP_CAPTURE);
  assign target_we = in_accept && idx_ok && (operation == OP_LOAD);

  assign elapsed_sum  = {1'b0, elapsed} + 33'(period_us);
  assign elapsed_next = elapsed_sum[32] ? '1 : elapsed_sum[31:0];

  always_comb begin
    if (phase_reg == PH_MOVE_A) begin
      prep_phase = PH_MOVE_A;
      prep_num   = elapsed;
      prep_den   = move_a_time;
    end else if (phase_reg == PH_HOLD && elapsed < 32'(hold_time)) begin
      prep_phase = PH_HOLD;
      prep_num   = elapsed;
      prep_den   = move_a_time;
    end else begin
      prep_phase = PH_MOVE_B;
      prep_num   = (elapsed >= 32'(hold_time)) ? elapsed - 32'(hold_time) : 32'd0;
      prep_den   = move_b_time;
    end
  end

  assign trial         = {rem, dividend[DVW-1]};
  assign trial_ok      = (trial >= {1'b0, div_den});
  assign dividend_next = {dividend[DVW-2:0], trial_ok};

  assign w_sel      = (tick_phase == PH_HOLD) ? '0 : rom_q;
  assign elem_last  = (elem == IW'(POSE_ELEMENTS - 1));
  assign offset_hit = (CMPW'(elem) == CMPW'(offset_element));
  assign b_sel      = offset_hit ? clamp_elem(SUMW'(target_q) + SUMW'(b_offset)) : target_q;
  assign sum        = SUMW'(a_reg) + ((SUMW'(prod) + SUMW'(32768)) >>> 16);

  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[wr_addr] <= element_value[EB-1:0];
    end
    start_q <= start_mem[elem];
  end

  always_ff @(posedge clk) begin
    if (target_we) begin
      target_mem[wr_addr] <= element_value[EB-1:0];
    end
    target_q <= target_mem[elem];
  end

  always_ff @(posedge clk) begin
    rom_q <= blend_rom[k_reg];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_a_time    <= RST_MOVE_A_TIME;
      hold_time      <= RST_HOLD_TIME;
      move_b_time    <= RST_MOVE_B_TIME;
      b_offset       <= RST_B_OFFSET;
      offset_element <= RST_OFFSET_ELEMENT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MOVE_A_TIME:    move_a_time    <= cfg_data[TIME_W-1:0];
        CFG_HOLD_TIME:      hold_time      <= cfg_data[TIME_W-1:0];
        CFG_MOVE_B_TIME:    move_b_time    <= cfg_data[TIME_W-1:0];
        CFG_B_OFFSET:       b_offset       <= cfg_data;
        CFG_OFFSET_ELEMENT: offset_element <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elapsed   <= '0;
      phase_reg <= PH_MOVE_A;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (operation == OP_TICK) begin
              elapsed <= elapsed_next;
              state   <= S_PREP;
            end else if (start_we) begin
              elapsed   <= '0;
              phase_reg <= PH_MOVE_A;
            end
          end
        end
        S_PREP: begin
          tick_phase <= prep_phase;
          div_num    <= prep_num[TIME_W-1:0];
          div_den    <= prep_den;
          elem       <= '0;
          if (prep_phase == PH_MOVE_A && elapsed >= 32'(move_a_time)) begin
            phase_reg <= PH_HOLD;
            elapsed   <= '0;
          end
          if (prep_phase == PH_MOVE_B) begin
            phase_reg <= PH_MOVE_B;
          end
          if (prep_phase == PH_HOLD) begin
            state <= S_READ;
          end else if (prep_den == '0 || prep_num >= 32'(prep_den)) begin
            k_reg <= KW'(BLEND_TABLE_DEPTH);
            state <= S_ROM;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          dividend  <= DVW'(div_num) * DVW'(BLEND_TABLE_DEPTH);
          rem       <= '0;
          div_count <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          dividend  <= dividend_next;
          rem       <= trial_ok ? TIME_W'(trial - {1'b0, div_den}) : trial[TIME_W-1:0];
          div_count <= div_count + CNTW'(1);
          if (div_count == CNTW'(DVW - 1)) begin
            k_reg <= dividend_next[KW-1:0];
            state <= S_ROM;
          end
        end
        S_ROM: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_BSEL;
        end
        S_BSEL: begin
          if (tick_phase == PH_MOVE_A) begin
            a_reg <= start_q;
            b_reg <= target_q;
          end else begin
            a_reg <= target_q;
            b_reg <= b_sel;
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff  <= DW'(b_reg) - DW'(a_reg);
          state <= S_PROD;
        end
        S_PROD: begin
          prod  <= PW'(diff) * PW'(signed'({1'b0, w_sel}));
          state <= S_SUM;
        end
        S_SUM: begin
          pose_value <= VALUE_W'(clamp_elem(sum));
          out_index  <= INDEX_W'(elem);
          phase      <= tick_phase;
          last       <= elem_last;
          out_valid  <= 1'b1;
          state      <= S_OUTW;
        end
        S_OUTW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (elem_last) begin
              state <= S_IDLE;
            end else begin
              elem  <= elem + IW'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result beat is pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !in_stall)
    else $error("block did not return to idle after the last beat of a tick");

  a_move_a_not_b: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == PH_MOVE_A) |-> (phase_reg != PH_MOVE_B))
    else $error("phase register reached the second move during a first-move tick");

endmodule

// ===== tb/tb_cosine_blend_pose_sequencer_unit.sv =====
// Self-checking testbench for the cosine blend pose sequencer, with a built-in predictor.
`timescale 1ns / 1ps

module tb_cosine_blend_pose_sequencer_unit;
  import cbps_pkg::*;

  localparam int POSE_COUNT    = 16;
  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 180;
  localparam int SEGMENTS      = 5;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int PRINT_CAP     = 100;

  localparam op_t      OP_UNUSED    = 2'd3;
  localparam cfg_idx_t CFG_SPARE_LO = 3'd5;
  localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

  localparam logic [TIME_W-1:0]   TIME_MAX   = 27'h7FF_FFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 20'hF_FFFF;
  localparam logic [VALUE_W-1:0]  VALUE_MAX  = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0]  VALUE_MIN  = 32'h8000_0000;
  localparam longint POSE_HI = 64'sd2147483647;
  localparam longint POSE_LO = -64'sd2147483648;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              reg_sel;
    op_t                   op;
    logic [INDEX_W-1:0]    idx;
    logic [VALUE_W-1:0]    val;
    logic [PERIOD_W-1:0]   per;
    logic                  typed;
    phase_t                exp_ph;
    logic [VALUE_W-1:0]    exp_val;
  } plan_row_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
    phase_t             ph;
    logic               last;
  } pose_beat_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               operation;
  logic [INDEX_W-1:0]       element_index;
  logic signed [VALUE_W-1:0] element_value;
  logic [PERIOD_W-1:0]      period_us;
  logic                     out_valid;
  logic                     out_stall;
  logic [INDEX_W-1:0]       out_index;
  logic signed [VALUE_W-1:0] pose_value;
  logic [1:0]               phase;
  logic                     last;

  cosine_blend_pose_sequencer_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .element_index (element_index),
    .element_value (element_value),
    .period_us     (period_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_index     (out_index),
    .pose_value    (pose_value),
    .phase         (phase),
    .last          (last)
  );

  int unsigned move_a_us;
  int unsigned hold_us;
  int unsigned move_b_us;
  int unsigned offset_sel;
  longint      b_offset_q328;
  longint      start_elem [POSE_COUNT];
  longint      target_elem [POSE_COUNT];
  int unsigned elapsed_us;
  phase_t      seq_phase;

  pose_beat_t expected_poses[$];
  plan_row_t  plan[$];
  pose_beat_t head;
  int         mismatches = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected result beat", pose_value, '0);
      end else begin
        head = expected_poses.pop_front();
        if (out_index !== head.idx) report_mismatch("out_index", out_index, head.idx);
        if (pose_value !== head.value) report_mismatch("pose_value", pose_value, head.value);
        if (phase !== head.ph) report_mismatch("phase", phase, head.ph);
        if (last !== head.last) report_mismatch("last", last, head.last);
      end
    end
  end

  function automatic longint unsigned sin_sq_q16(input longint unsigned k);
    longint unsigned y, t, s, den;
    int n;
    y = (PI_Q30 * k) / (2 * TABLE_DEPTH);
    t = y;
    s = y;
    for (n = 1; n <= 6; n++) begin
      t = (t * y) >> 30;
      t = (t * y) >> 30;
      den = (2 * n) * (2 * n + 1);
      t = t / den;
      if (n % 2 == 1) s = (s > t) ? s - t : 0;
      else s = s + t;
    end
    s = (s * s) >> 30;
    return (s + 8192) >> 14;
  endfunction

  function automatic longint blend_weight(input longint unsigned k);
    longint unsigned kk;
    kk = (k > TABLE_DEPTH) ? TABLE_DEPTH : k;
    if (2 * kk <= TABLE_DEPTH) return longint'(sin_sq_q16(kk));
    return 65536 - longint'(sin_sq_q16(TABLE_DEPTH - kk));
  endfunction

  function automatic longint unsigned table_index(input int unsigned num,
                                                  input int unsigned den);
    longint unsigned prod;
    if (den == 0 || num >= den) return TABLE_DEPTH;
    prod = num;
    prod = prod * TABLE_DEPTH;
    return prod / den;
  endfunction

  function automatic longint clamp_pose(input longint v);
    if (v > POSE_HI) return POSE_HI;
    if (v < POSE_LO) return POSE_LO;
    return v;
  endfunction

  function automatic longint mix(input longint a, input longint b, input longint w);
    longint p, q;
    p = (b - a) * w + 32768;
    if (p >= 0) q = p / 65536;
    else q = -((-p + 65535) / 65536);
    return clamp_pose(a + q);
  endfunction

  task automatic reset_sequence();
    logic signed [VALUE_W-1:0] sdata;
    int i;
    move_a_us  = RST_MOVE_A_TIME;
    hold_us    = RST_HOLD_TIME;
    move_b_us  = RST_MOVE_B_TIME;
    sdata      = RST_B_OFFSET;
    b_offset_q328 = sdata;
    offset_sel = RST_OFFSET_ELEMENT;
    for (i = 0; i < POSE_COUNT; i++) begin
      start_elem[i]  = 0;
      target_elem[i] = 0;
    end
    elapsed_us = 0;
    seq_phase  = PH_MOVE_A;
  endtask

  task automatic advance_sequence(input plan_row_t r);
    logic signed [VALUE_W-1:0] sval;
    longint      elem, goal, v, w;
    int unsigned rel;
    phase_t      ph;
    pose_beat_t  b;
    int          i;
    sval = r.val;
    elem = sval;
    case (r.op)
      OP_LOAD: target_elem[r.idx] = elem;
      OP_CAPTURE: begin
        start_elem[r.idx] = elem;
        elapsed_us = 0;
        seq_phase  = PH_MOVE_A;
      end
      OP_TICK: begin
        if (elapsed_us > 32'hFFFF_FFFF - r.per) elapsed_us = 32'hFFFF_FFFF;
        else elapsed_us = elapsed_us + r.per;
        ph = seq_phase;
        w  = 0;
        if (ph == PH_MOVE_A) begin
          w = blend_weight(table_index(elapsed_us, move_a_us));
        end else if (!(ph == PH_HOLD && elapsed_us < hold_us)) begin
          rel = (elapsed_us >= hold_us) ? elapsed_us - hold_us : 0;
          ph = PH_MOVE_B;
          seq_phase = PH_MOVE_B;
          w = blend_weight(table_index(rel, move_b_us));
        end
        for (i = 0; i < POSE_COUNT; i++) begin
          if (ph == PH_MOVE_A) begin
            v = mix(start_elem[i], target_elem[i], w);
          end else if (ph == PH_HOLD) begin
            v = target_elem[i];
          end else begin
            goal = target_elem[i];
            if (i == offset_sel) goal = clamp_pose(goal + b_offset_q328);
            v = mix(target_elem[i], goal, w);
          end
          b.idx   = i[INDEX_W-1:0];
          b.value = v[VALUE_W-1:0];
          b.ph    = ph;
          b.last  = (i == POSE_COUNT - 1);
          expected_poses.push_back(b);
        end
        if (ph == PH_MOVE_A && elapsed_us >= move_a_us) begin
          seq_phase  = PH_HOLD;
          elapsed_us = 0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic plan_row_t beat_row(input op_t op, input logic [INDEX_W-1:0] idx,
                                         input logic [VALUE_W-1:0] val,
                                         input logic [PERIOD_W-1:0] per);
    plan_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.op   = op;
    r.idx  = idx;
    r.val  = val;
    r.per  = per;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic [PERIOD_W-1:0] per,
                                         input logic [INDEX_W-1:0] idx, input phase_t ph,
                                         input logic [VALUE_W-1:0] want);
    plan_row_t r;
    r = beat_row(OP_TICK, idx, '0, per);
    r.typed   = 1'b1;
    r.exp_ph  = ph;
    r.exp_val = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_sel = sel;
    r.val     = data;
    return r;
  endfunction

  task automatic send_beat(input plan_row_t r);
    pose_beat_t b;
    int base;
    int k;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= r.op;
    element_index <= r.idx;
    element_value <= r.val;
    period_us     <= r.per;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    base = expected_poses.size();
    advance_sequence(r);
    if (r.typed) begin
      for (k = base; k < expected_poses.size(); k++) begin
        b = expected_poses[k];
        b.ph = r.exp_ph;
        if (b.idx == r.idx) b.value = r.exp_val;
        expected_poses[k] = b;
      end
    end
  endtask

  task automatic write_register(input cfg_idx_t sel, input logic [CFG_DATA_W-1:0] data);
    logic signed [VALUE_W-1:0] sdata;
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    sdata = data;
    case (sel)
      CFG_MOVE_A_TIME:    move_a_us = data[TIME_W-1:0];
      CFG_HOLD_TIME:      hold_us = data[TIME_W-1:0];
      CFG_MOVE_B_TIME:    move_b_us = data[TIME_W-1:0];
      CFG_B_OFFSET:       b_offset_q328 = sdata;
      CFG_OFFSET_ELEMENT: offset_sel = data[INDEX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] duration_word();
    logic [CFG_DATA_W-1:0] word;
    logic [31:0] pick;
    int roll;
    word = $urandom;
    roll = $urandom_range(0, 9);
    pick = $urandom_range(1, 6000);
    case (roll)
      0: word[TIME_W-1:0] = '0;
      1: word[TIME_W-1:0] = TIME_MAX;
      2: word[TIME_W-1:0] = 27'd1;
      3: ;
      default: word[TIME_W-1:0] = pick[TIME_W-1:0];
    endcase
    return word;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    logic [31:0] word;
    int roll;
    roll = $urandom_range(0, 9);
    word = $urandom;
    if (roll == 0) return '0;
    if (roll == 1) return PERIOD_MAX;
    if (roll == 2) return word[PERIOD_W-1:0];
    word = $urandom_range(0, 2000);
    return word[PERIOD_W-1:0];
  endfunction

  task automatic shuffle_registers();
    logic [31:0] word;
    int roll;
    write_register(CFG_MOVE_A_TIME, duration_word());
    write_register(CFG_HOLD_TIME, duration_word());
    write_register(CFG_MOVE_B_TIME, duration_word());
    roll = $urandom_range(0, 5);
    word = $urandom;
    if (roll == 0) word = VALUE_MAX;
    else if (roll == 1) word = VALUE_MIN;
    else if (roll > 2) word = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
    write_register(CFG_B_OFFSET, word);
    word = $urandom;
    write_register(CFG_OFFSET_ELEMENT, word);
    if ($urandom_range(0, 3) == 0) begin
      word = $urandom;
      write_register(CFG_SPARE_LO + cfg_idx_t'($urandom_range(0, 2)), word);
    end
  endtask

  function automatic plan_row_t random_row();
    logic [31:0] word1, word2;
    int roll;
    word1 = $urandom;
    word2 = $urandom;
    roll  = $urandom_range(0, 99);
    if (roll < 64) return beat_row(OP_TICK, word1[3:0], word2, pick_period());
    if (roll < 78) return beat_row(OP_LOAD, word1[3:0], word2, word1[31:12]);
    if (roll < 90) return beat_row(OP_CAPTURE, word1[3:0], word2, word1[31:12]);
    return beat_row(OP_UNUSED, word1[3:0], word2, word1[31:12]);
  endfunction

  initial begin
    logic [31:0] word;
    plan_row_t   r;
    bit          after_beat;
    int          i, n, seg, counted;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_MOVE_A_TIME;
    cfg_data      = '0;
    in_valid      = 1'b0;
    operation     = OP_LOAD;
    element_index = '0;
    element_value = '0;
    period_us     = '0;
    reset_sequence();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every pose entry is written before the first tick reads it.
    for (i = 0; i < POSE_COUNT; i++) begin
      word = $urandom;
      send_beat(beat_row(OP_LOAD, i[3:0], word, '0));
      word = $urandom;
      send_beat(beat_row(OP_CAPTURE, i[3:0], word, '0));
    end

    plan.push_back(beat_row(OP_CAPTURE, 4'd5, 32'h1000_0000, '0));
    plan.push_back(tick_row('0, 4'd5, PH_MOVE_A, 32'h1000_0000));
    plan.push_back(beat_row(OP_TICK, '0, '0, 20'd1000000));
    plan.push_back(reg_row(CFG_MOVE_A_TIME, 32'd1000));
    plan.push_back(reg_row(CFG_HOLD_TIME, 32'd500));
    plan.push_back(reg_row(CFG_MOVE_B_TIME, 32'd1000));
    plan.push_back(reg_row(CFG_B_OFFSET, VALUE_MAX));
    plan.push_back(reg_row(CFG_OFFSET_ELEMENT, 32'd15));
    plan.push_back(beat_row(OP_UNUSED, 4'd5, 32'hA5A5_5A5A, 20'd7));
    plan.push_back(beat_row(OP_LOAD, 4'd0, VALUE_MAX, '0));
    plan.push_back(beat_row(OP_CAPTURE, 4'd0, VALUE_MIN, '0));
    plan.push_back(tick_row('0, 4'd0, PH_MOVE_A, VALUE_MIN));
    plan.push_back(beat_row(OP_TICK, '0, '0, 20'd500));
    plan.push_back(tick_row(PERIOD_MAX, 4'd0, PH_MOVE_A, VALUE_MAX));
    plan.push_back(tick_row('0, 4'd0, PH_HOLD, VALUE_MAX));
    plan.push_back(beat_row(OP_LOAD, 4'd15, 32'h7FFF_F000, '0));
    plan.push_back(tick_row(20'd499, 4'd15, PH_HOLD, 32'h7FFF_F000));
    plan.push_back(tick_row(20'd1, 4'd15, PH_MOVE_B, 32'h7FFF_F000));
    plan.push_back(beat_row(OP_TICK, '0, '0, 20'd500));
    plan.push_back(tick_row(PERIOD_MAX, 4'd15, PH_MOVE_B, VALUE_MAX));
    plan.push_back(beat_row(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, PERIOD_MAX));
    plan.push_back(reg_row(CFG_HOLD_TIME, 32'd100000000));
    plan.push_back(tick_row(20'd1, 4'd15, PH_MOVE_B, 32'h7FFF_F000));
    plan.push_back(reg_row(CFG_B_OFFSET, VALUE_MIN));
    plan.push_back(reg_row(CFG_MOVE_A_TIME, 32'd0));
    plan.push_back(reg_row(CFG_MOVE_B_TIME, 32'd0));
    plan.push_back(reg_row(CFG_HOLD_TIME, 32'd0));
    plan.push_back(beat_row(OP_LOAD, 4'd15, 32'h8000_0100, '0));
    plan.push_back(tick_row('0, 4'd15, PH_MOVE_B, VALUE_MIN));
    plan.push_back(beat_row(OP_CAPTURE, 4'd15, 32'h0000_0000, '0));
    plan.push_back(tick_row('0, 4'd15, PH_MOVE_A, 32'h8000_0100));
    plan.push_back(tick_row('0, 4'd15, PH_MOVE_B, VALUE_MIN));
    plan.push_back(reg_row(CFG_MOVE_A_TIME, {5'b11111, TIME_MAX}));
    plan.push_back(reg_row(CFG_HOLD_TIME, {5'b10101, TIME_MAX}));
    plan.push_back(reg_row(CFG_MOVE_B_TIME, {5'b01010, TIME_MAX}));
    plan.push_back(reg_row(CFG_B_OFFSET, 32'd0));
    plan.push_back(reg_row(CFG_OFFSET_ELEMENT, 32'hFFFF_FFF0));
    plan.push_back(reg_row(CFG_SPARE_LO, 32'hDEAD_BEEF));
    plan.push_back(reg_row(CFG_SPARE_HI, 32'hFFFF_FFFF));
    plan.push_back(beat_row(OP_CAPTURE, 4'd3, 32'h1234_5678, '0));
    plan.push_back(beat_row(OP_TICK, '0, '0, PERIOD_MAX));
    plan.push_back(beat_row(OP_TICK, 4'hF, 32'hFFFF_FFFF, PERIOD_MAX));
    plan.push_back(beat_row(OP_LOAD, 4'd0, 32'h0000_0000, '0));
    plan.push_back(beat_row(OP_TICK, '0, '0, '0));

    after_beat = 1'b1;
    for (n = 0; n < plan.size(); n++) begin
      if (plan[n].kind == ROW_REG) begin
        if (after_beat) settle();
        write_register(plan[n].reg_sel, plan[n].val);
        after_beat = 1'b0;
      end else begin
        send_beat(plan[n]);
        after_beat = 1'b1;
      end
    end

    counted = 0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      shuffle_registers();
      calm = (seg == 2);
      while (counted < (seg + 1) * (RANDOM_ITEMS / SEGMENTS)) begin
        r = random_row();
        send_beat(r);
        if (r.op != OP_UNUSED) counted++;
        if ($urandom_range(0, 49) == 0) drain();
      end
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
